### rtl/core/lsfc_pkg.sv
// Shared types, constants and color table for the LED severity fade controller.
package lsfc_pkg;

  localparam int unsigned ChW = 8;

  typedef enum logic [1:0] {
    OP_SET   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_TICK  = 2'd2,
    OP_FORCE = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    SEV_INFO     = 2'd0,
    SEV_CRITICAL = 2'd1,
    SEV_WARNING  = 2'd2,
    SEV_MONEY    = 2'd3
  } sev_e;

  typedef struct packed {
    logic [ChW-1:0] red;
    logic [ChW-1:0] green;
    logic [ChW-1:0] blue;
  } rgb_t;

  // kill: forget the last emitted color, so the result is always delivered
  typedef struct packed {
    logic kill;
    rgb_t colour;
  } req_t;

  function automatic rgb_t sev_colour(sev_e sev);
    rgb_t c;
    case (sev)
      SEV_CRITICAL: c = '{red: 8'hFF, green: 8'h00, blue: 8'h00};
      SEV_WARNING:  c = '{red: 8'hFF, green: 8'hC8, blue: 8'h00};
      SEV_MONEY:    c = '{red: 8'h00, green: 8'hFF, blue: 8'h00};
      default:      c = '0;
    endcase
    return c;
  endfunction

endpackage

### rtl/core/lsfc_ifs.sv
// Valid/ready channel interfaces for input beats and result beats.
interface lsfc_item_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [1:0]  severity;
  logic [31:0] now_ms;

  modport source(output valid, output operation, output severity, output now_ms, input ready);
  modport sink(input valid, input operation, input severity, input now_ms, output ready);
endinterface

interface lsfc_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source(output valid, output red, output green, output blue, input ready);
  modport sink(input valid, input red, input green, input blue, output ready);
endinterface

### rtl/core/led_severity_fade_controller.sv
// Top level: severity/fade control, fade scaler and change-filtered result register.
// Path: an accepted input beat is held in the input register; its result is then
//   captured in the result register when the result side does not stall.
// Throughput: one input beat per cycle; all work for a beat is one combinational pass
//   between the two registers, and the input stalls only while both are held.
// Reset: rst_ni clears control state (not data regs); led_present is 1, nothing held.
module led_severity_fade_controller #(
  parameter int unsigned FADE_DURATION_MS = 300
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 cfg_wdata_i,
  lsfc_item_if.sink            item_i,
  lsfc_result_if.source        result_o
);

  localparam int unsigned RemW = $clog2(FADE_DURATION_MS + 1);

  logic                 led_present_q;
  logic                 in_vld_q;
  lsfc_pkg::op_e        in_op_q;
  lsfc_pkg::sev_e       in_sev_q;
  logic [31:0]          in_now_q;
  lsfc_pkg::sev_e       held_q, held_d;
  logic                 fade_act_q, fade_act_d;
  lsfc_pkg::rgb_t       fade_col_q, fade_col_d;
  logic [31:0]          fade_start_q, fade_start_d;
  logic                 fade_started_q, fade_started_d;
  lsfc_pkg::rgb_t       last_q;
  logic                 last_vld_q;
  lsfc_pkg::rgb_t       out_q;
  logic                 out_vld_q;

  logic                 accept;
  logic                 take;
  logic                 clr;
  logic [31:0]          start_eff;
  logic [31:0]          elapsed;
  logic                 fade_done;
  logic [RemW-1:0]      remain;
  lsfc_pkg::rgb_t       fade_scaled;
  logic                 req_vld;
  lsfc_pkg::req_t       req;
  logic                 out_free;
  logic                 emit;
  logic                 res_fire;

  assign out_free     = !out_vld_q || result_o.ready;
  assign take         = in_vld_q && out_free;
  assign item_i.ready = !in_vld_q || out_free;
  assign accept       = item_i.valid && item_i.ready;

  assign clr       = (in_op_q == lsfc_pkg::OP_CLEAR) ||
                     ((in_op_q == lsfc_pkg::OP_SET) && (in_sev_q == lsfc_pkg::SEV_INFO));
  assign start_eff = fade_started_q ? fade_start_q : in_now_q;
  assign elapsed   = in_now_q - start_eff;
  assign fade_done = elapsed >= 32'(FADE_DURATION_MS);
  assign remain    = RemW'(32'(FADE_DURATION_MS) - elapsed);

  lsfc_fade_pipe #(
    .FADE_MS (FADE_DURATION_MS)
  ) u_scale (
    .colour_i (fade_col_q),
    .remain_i (remain),
    .colour_o (fade_scaled)
  );

  always_comb begin
    held_d         = held_q;
    fade_act_d     = fade_act_q;
    fade_col_d     = fade_col_q;
    fade_start_d   = fade_start_q;
    fade_started_d = fade_started_q;
    req_vld        = 1'b0;
    req.kill       = 1'b0;
    req.colour     = lsfc_pkg::sev_colour(held_q);
    if (take) begin
      if (clr) begin
        if (held_q != lsfc_pkg::SEV_INFO) begin
          fade_col_d     = lsfc_pkg::sev_colour(held_q);
          fade_act_d     = 1'b1;
          fade_started_d = 1'b0;
          fade_start_d   = '0;
        end
        held_d = lsfc_pkg::SEV_INFO;
      end else begin
        case (in_op_q)
          lsfc_pkg::OP_SET: begin
            if (led_present_q) begin
              held_d     = in_sev_q;
              fade_act_d = 1'b0;
            end
          end
          lsfc_pkg::OP_TICK: begin
            if (held_q != lsfc_pkg::SEV_INFO) begin
              req_vld = 1'b1;
            end else if (fade_act_q) begin
              fade_started_d = 1'b1;
              fade_start_d   = start_eff;
              req_vld        = 1'b1;
              if (fade_done) begin
                fade_act_d = 1'b0;
                req.colour = '0;
              end else begin
                req.colour = fade_scaled;
              end
            end
          end
          lsfc_pkg::OP_FORCE: begin
            held_d     = lsfc_pkg::SEV_INFO;
            fade_act_d = 1'b0;
            req_vld    = 1'b1;
            req.kill   = 1'b1;
            req.colour = '0;
          end
          default: ;
        endcase
      end
    end
  end

  assign emit     = req.kill || !last_vld_q || (req.colour != last_q);
  assign res_fire = take && req_vld && emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      led_present_q  <= 1'b1;
      in_vld_q       <= 1'b0;
      held_q         <= lsfc_pkg::SEV_INFO;
      fade_act_q     <= 1'b0;
      fade_col_q     <= '0;
      fade_start_q   <= '0;
      fade_started_q <= 1'b0;
      last_q         <= '0;
      last_vld_q     <= 1'b0;
      out_vld_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        led_present_q <= cfg_wdata_i;
      end
      if (item_i.ready) begin
        in_vld_q <= item_i.valid;
      end
      held_q         <= held_d;
      fade_act_q     <= fade_act_d;
      fade_col_q     <= fade_col_d;
      fade_start_q   <= fade_start_d;
      fade_started_q <= fade_started_d;
      if (out_free) begin
        out_vld_q <= res_fire;
      end
      if (res_fire) begin
        last_q     <= req.colour;
        last_vld_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_op_q  <= lsfc_pkg::op_e'(item_i.operation);
      in_sev_q <= lsfc_pkg::sev_e'(item_i.severity);
      in_now_q <= item_i.now_ms;
    end
    if (res_fire) begin
      out_q <= req.colour;
    end
  end

  assign result_o.valid = out_vld_q;
  assign result_o.red   = out_q.red;
  assign result_o.green = out_q.green;
  assign result_o.blue  = out_q.blue;

endmodule

### rtl/core/lsfc_fade_pipe.sv
// Combinational per-channel fade scaler: v*(F-e)/F rounded half up, by reciprocal multiply.
module lsfc_fade_pipe #(
  parameter int unsigned FADE_MS = 300
) (
  input  lsfc_pkg::rgb_t                 colour_i,
  input  logic [$clog2(FADE_MS+1)-1:0]   remain_i,
  output lsfc_pkg::rgb_t                 colour_o
);

  localparam int unsigned RemW = $clog2(FADE_MS + 1);
  localparam int unsigned ChW  = lsfc_pkg::ChW;
  localparam int unsigned NumW = RemW + ChW + 1;
  localparam int unsigned DivW = $clog2(2 * FADE_MS);
  localparam int unsigned Sh   = NumW + DivW;
  localparam int unsigned RcpW = NumW + 2;
  localparam int unsigned PrdW = NumW + RcpW;
  localparam longint unsigned Dv  = 64'(2 * FADE_MS);
  localparam longint unsigned Rcp = ((64'd1 << Sh) + Dv - 64'd1) / Dv;
  localparam logic [RcpW-1:0] RcpV = RcpW'(Rcp);
  localparam logic [NumW-1:0] Half = NumW'(FADE_MS);

  logic [2:0][ChW-1:0] col_in;
  logic [2:0][ChW-1:0] col_out;

  assign col_in = colour_i;

  // numerator 2*v*r + F, then floor(num / 2F) as (num * ceil(2^Sh / 2F)) >> Sh
  for (genvar c = 0; c < 3; c++) begin : g_ch
    logic [NumW-1:0] num;
    logic [PrdW-1:0] prod;
    assign num        = ((NumW'(col_in[c]) * NumW'(remain_i)) << 1) + Half;
    assign prod       = PrdW'(num) * PrdW'(RcpV);
    assign col_out[c] = prod[Sh +: ChW];
  end

  assign colour_o = col_out;

endmodule

### rtl/core/lsfc_checker.sv
// Port-level assertions for the LED severity fade controller, bound to the top level.
module lsfc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic [1:0] in_operation_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_red_i,
  input logic [7:0] out_green_i,
  input logic [7:0] out_blue_i
);

  logic force_beat;
  assign force_beat = in_valid_i && in_ready_i && (in_operation_i == lsfc_pkg::OP_FORCE);

  // stalled result beat keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i &&
      $stable(out_red_i) && $stable(out_green_i) && $stable(out_blue_i))
  else $error("result beat changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
  else $error("result beat dropped while stalled");

  // force clear always gives black, via the input register, then the result register, when the sink is free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    force_beat ##1 out_ready_i
    |=> out_valid_i && (out_red_i == 8'd0) && (out_green_i == 8'd0) && (out_blue_i == 8'd0))
  else $error("force clear did not deliver black on time");

  assert property (@(posedge clk_i) !rst_ni |-> !out_valid_i)
  else $error("result valid during reset");

endmodule

bind led_severity_fade_controller lsfc_checker u_lsfc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (item_i.valid),
  .in_ready_i     (item_i.ready),
  .in_operation_i (item_i.operation),
  .out_valid_i    (result_o.valid),
  .out_ready_i    (result_o.ready),
  .out_red_i      (result_o.red),
  .out_green_i    (result_o.green),
  .out_blue_i     (result_o.blue)
);
